// File: design/row_strip_range_index_top_defines.svh
// Assertion macros for the checker file rsri_check.sv
`ifndef ROW_STRIP_RANGE_INDEX_TOP_DEFINES_SVH
`define ROW_STRIP_RANGE_INDEX_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define RSRI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define RSRI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rsri_pkg.sv
package rsri_pkg;

    // Request kinds on the item channel
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Operations carried along the cell chain
    localparam logic [1:0] OP_NOP    = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // Configuration register indexes
    localparam logic REG_STRIP_OFFSET = 1'b0;
    localparam logic REG_STRIP_COUNT  = 1'b1;

    localparam int IDX_W = 15;   // component index width
    localparam int ROW_W = 16;   // row number width
    localparam int HGT_W = 15;   // height width
    localparam int CNT_W = 9;    // strip count register width
    localparam int DW    = 19;   // row distance from offset, signed, no wrap

    // Request as it travels from cell to cell, with the running merge
    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic             any;
        logic [IDX_W-1:0] mn;
        logic [IDX_W-1:0] mx;
        logic             err;
    } rsri_req_t;

endpackage

// File: design/rsri_item_if.sv
interface rsri_item_if
    import rsri_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [IDX_W-1:0]        root_index;
    logic signed [ROW_W-1:0] y_top;
    logic [HGT_W-1:0]        height;
    logic signed [ROW_W-1:0] y_bottom;

    modport source (output valid, kind, root_index, y_top, height, y_bottom, input ready);
    modport sink   (input valid, kind, root_index, y_top, height, y_bottom, output ready);
endinterface

// File: design/rsri_result_if.sv
interface rsri_result_if
    import rsri_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W:0]   after_index;
    logic             range_error;

    modport source (output valid, found, first_index, after_index, range_error, input ready);
    modport sink   (input valid, found, first_index, after_index, range_error, output ready);
endinterface

// File: design/rsri_cfg_if.sv
interface rsri_cfg_if
    import rsri_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             index;
    logic [ROW_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/rsri_decode.sv
module rsri_decode
    import rsri_pkg::*;
#(
    parameter int MAX_STRIPS  = 256,
    parameter int STRIP_SHIFT = 7,
    parameter int SW          = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [1:0]              kind,
    input  logic [IDX_W-1:0]        root_index,
    input  logic signed [ROW_W-1:0] y_top,
    input  logic [HGT_W-1:0]        height,
    input  logic signed [ROW_W-1:0] y_bottom,
    input  logic signed [ROW_W-1:0] strip_offset,
    input  logic [CNT_W-1:0]        strip_count,
    output logic                    out_valid,
    output logic [SW-1:0]           out_lo,
    output logic [SW-1:0]           out_hi,
    output rsri_req_t               out_req
);

    localparam logic signed [DW-1:0] MAX_S = DW'(MAX_STRIPS);

    // Stage A: row distances from strip zero
    logic                    a_valid_reg;
    logic [1:0]              a_kind_reg;
    logic [IDX_W-1:0]        a_idx_reg;
    logic                    a_zero_reg;
    logic signed [DW-1:0]    a_d1_reg;
    logic signed [DW-1:0]    a_d2_reg;
    logic signed [DW-1:0]    top_x;
    logic signed [DW-1:0]    bot_x;
    logic signed [DW-1:0]    off_x;
    logic signed [DW-1:0]    hgt_x;
    logic signed [DW-1:0]    d2_next;

    assign top_x = DW'(y_top);
    assign bot_x = DW'(y_bottom);
    assign off_x = DW'(strip_offset);
    assign hgt_x = $signed({{(DW-HGT_W){1'b0}}, height});

    always_comb
    begin
        if (kind == KIND_INSERT)
            d2_next = top_x + hgt_x - DW'(1) - off_x;
        else
            d2_next = bot_x - off_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_kind_reg <= kind;
            a_idx_reg  <= root_index;
            a_zero_reg <= (height == '0);
            a_d1_reg   <= top_x - off_x;
            a_d2_reg   <= d2_next;
        end
    end

    // Stage B: strip numbers, range check, clamp and swap
    logic signed [DW-1:0] s1;
    logic signed [DW-1:0] s2;
    logic signed [DW-1:0] cnt;
    logic signed [DW-1:0] c1;
    logic signed [DW-1:0] c2;
    logic                 ins_err;
    logic [SW-1:0]        lo_next;
    logic [SW-1:0]        hi_next;
    rsri_req_t            req_next;

    assign s1 = a_d1_reg >>> STRIP_SHIFT;
    assign s2 = a_d2_reg >>> STRIP_SHIFT;

    // strip count as used: zero acts as one, capped at the table size
    always_comb
    begin
        if (strip_count == '0)
            cnt = DW'(1);
        else if ($signed({{(DW-CNT_W){1'b0}}, strip_count}) > MAX_S)
            cnt = MAX_S;
        else
            cnt = $signed({{(DW-CNT_W){1'b0}}, strip_count});
    end

    always_comb
    begin
        if (s1 < 0)
            c1 = '0;
        else if (s1 >= cnt)
            c1 = cnt - DW'(1);
        else
            c1 = s1;
        if (s2 < 0)
            c2 = '0;
        else if (s2 >= cnt)
            c2 = cnt - DW'(1);
        else
            c2 = s2;
    end

    assign ins_err = !a_zero_reg && ((s1 < 0) || (s2 >= cnt));

    always_comb
    begin
        req_next     = '0;
        req_next.idx = a_idx_reg;
        lo_next      = s1[SW-1:0];
        hi_next      = s2[SW-1:0];
        unique case (a_kind_reg)
            KIND_CLEAR:
                req_next.op = OP_CLEAR;
            KIND_INSERT:
            begin
                req_next.err = ins_err;
                req_next.op  = (a_zero_reg || ins_err) ? OP_NOP : OP_INSERT;
            end
            KIND_QUERY:
            begin
                req_next.op = OP_QUERY;
                if (c1 > c2)
                begin
                    lo_next = c2[SW-1:0];
                    hi_next = c1[SW-1:0];
                end
                else
                begin
                    lo_next = c1[SW-1:0];
                    hi_next = c2[SW-1:0];
                end
            end
            KIND_UNUSED:
                req_next.op = OP_NOP;
        endcase
    end

    logic                 b_valid_reg;
    logic [SW-1:0]        b_lo_reg;
    logic [SW-1:0]        b_hi_reg;
    rsri_req_t            b_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_lo_reg  <= lo_next;
            b_hi_reg  <= hi_next;
            b_req_reg <= req_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_lo    = b_lo_reg;
    assign out_hi    = b_hi_reg;
    assign out_req   = b_req_reg;

endmodule

// File: design/rsri_cell.sv
module rsri_cell
    import rsri_pkg::*;
#(
    parameter int STRIP = 0,
    parameter int SW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [SW-1:0] in_lo,
    input  logic [SW-1:0] in_hi,
    input  rsri_req_t     in_req,
    output logic          out_valid,
    output logic [SW-1:0] out_lo,
    output logic [SW-1:0] out_hi,
    output rsri_req_t     out_req
);

    localparam logic [SW-1:0] ID = SW'(STRIP);

    logic             used_reg;
    logic             used_next;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] first_next;
    logic [IDX_W-1:0] last_reg;
    logic [IDX_W-1:0] last_next;
    logic             hit;
    rsri_req_t        req_next;

    assign hit = in_valid && (in_lo <= ID) && (ID <= in_hi);

    // Strip entry update and merge into the passing request
    always_comb
    begin
        used_next  = used_reg;
        first_next = first_reg;
        last_next  = last_reg;
        req_next   = in_req;
        if (in_valid)
        begin
            unique case (in_req.op)
                OP_CLEAR:
                    used_next = 1'b0;
                OP_INSERT:
                begin
                    if (hit)
                    begin
                        if (!used_reg || in_req.idx < first_reg)
                            first_next = in_req.idx;
                        if (!used_reg || in_req.idx > last_reg)
                            last_next = in_req.idx;
                        used_next = 1'b1;
                    end
                end
                OP_QUERY:
                begin
                    if (hit && used_reg)
                    begin
                        if (!in_req.any || first_reg < in_req.mn)
                            req_next.mn = first_reg;
                        if (!in_req.any || last_reg > in_req.mx)
                            req_next.mx = last_reg;
                        req_next.any = 1'b1;
                    end
                end
                OP_NOP:
                    req_next = in_req;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            used_reg  <= used_next;
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            first_reg <= first_next;
            last_reg  <= last_next;
            out_lo    <= in_lo;
            out_hi    <= in_hi;
            out_req   <= req_next;
        end
    end

endmodule

// File: design/row_strip_range_index_top.sv
// Strip index over page components.
// Channels: item (clear / insert / query requests), result (one per request),
// cfg (writes strip_offset at index 0, strip_count at index 1; always ready).
// Write cfg only while no request is in flight.
// Each request passes a two-stage decoder (strip numbers, range check, clamp,
// swap) and then a chain of MAX_STRIPS cells, one per strip, moving one cell
// per cycle unless the chain holds; each cell updates its own strip entry or
// merges it into the request.
// Throughput is one request per cycle unless the chain holds: a new request
// may follow in the next cycle, and requests stay in order through the chain.
// When the receiver stalls with a result waiting, the whole chain holds and
// item.ready falls until the result is taken.
// Reset empties all strips and sets strip_offset to 0, strip_count to 1; no
// clearing pass is needed.
// An insert that leaves the strips in use is dropped and flagged by
// range_error.
module row_strip_range_index_top
    import rsri_pkg::*;
#(
    parameter int MAX_STRIPS  = 256,
    parameter int STRIP_SHIFT = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    rsri_item_if.sink   item,
    rsri_result_if.source result,
    rsri_cfg_if.sink    cfg
);

    localparam int SW = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;

    // Configuration registers
    logic signed [ROW_W-1:0] offset_reg;
    logic [CNT_W-1:0]        count_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            count_reg  <= CNT_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STRIP_OFFSET: offset_reg <= $signed(cfg.data);
                REG_STRIP_COUNT:  count_reg  <= cfg.data[CNT_W-1:0];
            endcase
        end
    end

    // Chain advances whenever the output slot is free or being emptied
    logic out_valid_reg;
    logic adv;

    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;

    logic          valid_c [MAX_STRIPS+1];
    logic [SW-1:0] lo_c    [MAX_STRIPS+1];
    logic [SW-1:0] hi_c    [MAX_STRIPS+1];
    rsri_req_t     req_c   [MAX_STRIPS+1];

    rsri_decode #(
        .MAX_STRIPS  (MAX_STRIPS),
        .STRIP_SHIFT (STRIP_SHIFT),
        .SW          (SW)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (item.valid),
        .kind         (item.kind),
        .root_index   (item.root_index),
        .y_top        (item.y_top),
        .height       (item.height),
        .y_bottom     (item.y_bottom),
        .strip_offset (offset_reg),
        .strip_count  (count_reg),
        .out_valid    (valid_c[0]),
        .out_lo       (lo_c[0]),
        .out_hi       (hi_c[0]),
        .out_req      (req_c[0])
    );

    // One cell per strip
    for (genvar i = 0; i < MAX_STRIPS; i++)
    begin : g_cell
        rsri_cell #(
            .STRIP (i),
            .SW    (SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (valid_c[i]),
            .in_lo     (lo_c[i]),
            .in_hi     (hi_c[i]),
            .in_req    (req_c[i]),
            .out_valid (valid_c[i+1]),
            .out_lo    (lo_c[i+1]),
            .out_hi    (hi_c[i+1]),
            .out_req   (req_c[i+1])
        );
    end

    // Output register
    rsri_req_t        tail;
    logic             found_reg;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W:0]   after_reg;
    logic             err_reg;

    assign tail = req_c[MAX_STRIPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_c[MAX_STRIPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            found_reg <= tail.any;
            first_reg <= tail.any ? tail.mn : '0;
            after_reg <= tail.any ? ({1'b0, tail.mx} + (IDX_W+1)'(1)) : '0;
            err_reg   <= tail.err;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.found       = found_reg;
    assign result.first_index = first_reg;
    assign result.after_index = after_reg;
    assign result.range_error = err_reg;

endmodule

// File: design/rsri_check.sv
`include "row_strip_range_index_top_defines.svh"

module rsri_check
    import rsri_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic             found,
    input logic [IDX_W-1:0] first_index,
    input logic [IDX_W:0]   after_index,
    input logic             range_error
);

    logic               stalled;
    logic               res_hit;
    logic               res_miss;
    logic [IDX_W:0]     first_ext;
    logic [2*IDX_W:0]   idx_bits;
    logic [2*IDX_W+2:0] res_bits;

    // Views of the result channel
    assign stalled   = res_valid && !res_ready;
    assign res_hit   = res_valid && found;
    assign res_miss  = res_valid && !found;
    assign first_ext = {1'b0, first_index};
    assign idx_bits  = {first_index, after_index};
    assign res_bits  = {found, first_index, after_index, range_error};

    // A stalled result holds
    `RSRI_ASSERT_NEXT(a_hold, stalled, res_valid && $stable(res_bits), "stalled result changed")

    // Nothing found gives zero indexes
    `RSRI_ASSERT_ALWAYS(a_empty, res_miss |-> idx_bits == '0, "indexes set without a hit")

    // A hit gives a non-empty index range
    `RSRI_ASSERT_ALWAYS(a_order, res_hit |-> after_index > first_ext, "empty range on a hit")

    // Only queries find, only inserts fail
    `RSRI_ASSERT_ALWAYS(a_excl, res_hit |-> !range_error, "found with range_error")

endmodule

bind row_strip_range_index_top rsri_check u_rsri_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .found       (result.found),
    .first_index (result.first_index),
    .after_index (result.after_index),
    .range_error (result.range_error)
);
